FILE: design/hhbs_pkg.sv
package hhbs_pkg;

   localparam int HASH_W = 31;
   localparam int CNT_W = 31;
   localparam int VOTE_W = 32;

   localparam int MOD_STEP = 4;
   localparam int FRONT_STAGES = (HASH_W + MOD_STEP - 1) / MOD_STEP;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] FP_MUL1 = 32'h85ebca6b;
   localparam logic [31:0] FP_MUL2 = 32'hc2b2ae35;
   localparam logic [CNT_W-1:0] CNT_MAX = 31'h7FFFFFFF;

   localparam logic signed [33:0] VOTE_HI = 34'sd2147483647;
   localparam logic signed [33:0] VOTE_LO = -34'sd2147483648;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [HASH_W-1:0] fingerprint;
      logic [CNT_W-1:0]  counter;
      logic              is_real;
   } slot_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_EVAL,
      BK_WRITE
   } bk_state_type;

   function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? CNT_MAX : c + 31'd1;
   endfunction

   function automatic logic signed [VOTE_W-1:0] vote_sat_add(
      input logic signed [VOTE_W-1:0] v,
      input logic signed [VOTE_W:0]   d
   );
      logic signed [33:0] s;
      s = 34'(v) + 34'(d);
      if (s > VOTE_HI) begin
         return 32'sh7FFFFFFF;
      end else if (s < VOTE_LO) begin
         return 32'sh80000000;
      end
      return $signed(s[VOTE_W-1:0]);
   endfunction

endpackage

FILE: design/hhbs_if.sv
interface hhbs_req_if import hhbs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [HASH_W-1:0] flow_hash;

   modport source (output valid, req_type, flow_hash, input ready);
   modport sink (input valid, req_type, flow_hash, output ready);
endinterface

interface hhbs_rsp_if import hhbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] flow_count;

   modport source (output valid, flow_count, input ready);
   modport sink (input valid, flow_count, output ready);
endinterface

FILE: design/hhbs_front.sv
module hhbs_front import hhbs_pkg::*; #(
   parameter int NUM_BUCKETS = 512
) (
   input  logic                clock,
   input  logic                reset,
   hhbs_req_if.sink            req,
   input  logic                hold,
   input  queue_status_type    q_stat,
   output logic                ent_push,
   output logic                ent_type,
   output logic [((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1)-1:0] ent_bucket,
   output logic [HASH_W-1:0]   ent_fp
);

   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam logic [BW:0] NBK = NUM_BUCKETS[BW:0];
   localparam int LAST = FRONT_STAGES - 1;

   logic              valid_ff [FRONT_STAGES];
   logic              type_ff  [FRONT_STAGES];
   logic [HASH_W-1:0] hash_ff  [FRONT_STAGES];
   logic [BW-1:0]     rem_ff   [FRONT_STAGES];
   logic [31:0]       fpw_ff   [FRONT_STAGES];

   logic              valid_in [FRONT_STAGES];
   logic              type_in  [FRONT_STAGES];
   logic [HASH_W-1:0] hash_in  [FRONT_STAGES];
   logic [BW-1:0]     rem_in   [FRONT_STAGES];
   logic [31:0]       fpw_in   [FRONT_STAGES];

   logic              src_valid [FRONT_STAGES];
   logic              src_type  [FRONT_STAGES];
   logic [HASH_W-1:0] src_hash  [FRONT_STAGES];
   logic [BW-1:0]     src_rem   [FRONT_STAGES];
   logic [31:0]       src_fpw   [FRONT_STAGES];

   logic advance;

   assign advance = !valid_ff[LAST] || !q_stat.full;
   assign req.ready = advance && !hold;

   always_comb begin
      src_valid[0] = req.valid && req.ready;
      src_type[0] = req.req_type;
      src_hash[0] = req.flow_hash;
      src_rem[0] = '0;
      src_fpw[0] = {1'b0, req.flow_hash};
      for (int s = 1; s < FRONT_STAGES; s++) begin
         src_valid[s] = valid_ff[s-1];
         src_type[s] = type_ff[s-1];
         src_hash[s] = hash_ff[s-1];
         src_rem[s] = rem_ff[s-1];
         src_fpw[s] = fpw_ff[s-1];
      end
   end

   // Each stage folds up to MOD_STEP hash bits into the remainder, MSB first.
   always_comb begin
      int          b;
      logic [BW:0] t;
      logic [31:0] w;
      for (int s = 0; s < FRONT_STAGES; s++) begin
         valid_in[s] = src_valid[s];
         type_in[s] = src_type[s];
         hash_in[s] = src_hash[s];
         t = {1'b0, src_rem[s]};
         for (int j = 0; j < MOD_STEP; j++) begin
            b = HASH_W - 1 - s * MOD_STEP - j;
            if (b >= 0) begin
               t = {t[BW-1:0], src_hash[s][b]};
               if (t >= NBK) begin
                  t = t - NBK;
               end
            end
         end
         rem_in[s] = t[BW-1:0];
         w = src_fpw[s];
         if (s == 0) begin
            w = w ^ (w >> 16);
            w = 32'(w * FP_MUL1);
         end else if (s == 1) begin
            w = w ^ (w >> 13);
            w = 32'(w * FP_MUL2);
         end else if (s == 2) begin
            w = w ^ (w >> 16);
            w = {1'b0, w[HASH_W-1:0]};
         end
         fpw_in[s] = w;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < FRONT_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         for (int s = 0; s < FRONT_STAGES; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < FRONT_STAGES; s++) begin
            type_ff[s] <= type_in[s];
            hash_ff[s] <= hash_in[s];
            rem_ff[s] <= rem_in[s];
            fpw_ff[s] <= fpw_in[s];
         end
      end
   end

   assign ent_push = valid_ff[LAST] && !q_stat.full;
   assign ent_type = type_ff[LAST];
   assign ent_bucket = rem_ff[LAST];
   assign ent_fp = fpw_ff[LAST][HASH_W-1:0];

endmodule

FILE: design/hhbs_queue.sv
module hhbs_queue import hhbs_pkg::*; #(
   parameter int WIDTH = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type stat
);

   logic [WIDTH-1:0]       entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/hhbs_back.sv
module hhbs_back import hhbs_pkg::*; #(
   parameter int NUM_BUCKETS = 512,
   parameter int SLOTS_PER_BUCKET = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  logic [HASH_W + ((NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1):0] q_data,
   output logic             q_pop,
   output logic             clear_busy,
   hhbs_rsp_if.source       rsp
);

   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int IW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int TREE_W = 2 ** $clog2(SLOTS_PER_BUCKET);
   localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);

   slot_type [SLOTS_PER_BUCKET-1:0] slot_mem [NUM_BUCKETS];
   logic signed [VOTE_W-1:0]        vote_mem [NUM_BUCKETS];

   bk_state_type state_ff;
   bk_state_type state_in;
   logic [BW-1:0] clr_ff;

   logic              item_type_ff;
   logic [BW-1:0]     item_bucket_ff;
   logic [HASH_W-1:0] item_fp_ff;

   slot_type [SLOTS_PER_BUCKET-1:0] rd_row_ff;
   logic signed [VOTE_W-1:0]        rd_vote_ff;

   logic          hit_found_ff, hit_found_in;
   logic          hit_empty_ff, hit_empty_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic          qm_found_ff, qm_found_in;
   logic [IW-1:0] qm_idx_ff, qm_idx_in;
   logic [IW-1:0] min_idx_ff, min_idx_in;

   logic [31:0]   node_val [2*TREE_W];
   logic [IW-1:0] node_idx [2*TREE_W];

   logic                     wr_slot_ff, wr_slot_in;
   logic [IW-1:0]            wr_idx_ff, wr_idx_in;
   slot_type                 wr_val_ff, wr_val_in;
   logic signed [VOTE_W-1:0] vote_mid_ff, vote_mid_in;
   logic                     vote_step_ff, vote_step_in;
   logic [CNT_W-1:0]         cnt_out_ff, cnt_out_in;

   logic             rsp_valid_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic                            rd_en;
   logic                            mem_we;
   logic                            rsp_load;
   logic [BW-1:0]                   mem_addr;
   slot_type [SLOTS_PER_BUCKET-1:0] wr_row;
   logic signed [VOTE_W-1:0]        vote_fin;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_ff == LAST_BUCKET) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_stat.empty) begin
               state_in = BK_READ;
            end
         end
         BK_READ: state_in = BK_EVAL;
         BK_EVAL: state_in = BK_WRITE;
         BK_WRITE: begin
            if (item_type_ff == REQ_INSERT || !rsp_valid_ff || rsp.ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      rd_en = 1'b0;
      mem_we = 1'b0;
      rsp_load = 1'b0;
      clear_busy = 1'b0;
      mem_addr = item_bucket_ff;
      case (state_ff)
         BK_CLEAR: begin
            clear_busy = 1'b1;
            mem_we = 1'b1;
            mem_addr = clr_ff;
         end
         BK_IDLE: begin
            q_pop = !q_stat.empty;
            rd_en = !q_stat.empty;
         end
         BK_WRITE: begin
            mem_we = (item_type_ff == REQ_INSERT);
            rsp_load = (item_type_ff == REQ_QUERY) && (!rsp_valid_ff || rsp.ready);
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_addr] <= wr_row;
         vote_mem[mem_addr] <= vote_fin;
      end
      if (rd_en) begin
         rd_row_ff <= slot_mem[q_data[HASH_W +: BW]];
         rd_vote_ff <= vote_mem[q_data[HASH_W +: BW]];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_type_ff <= q_data[HASH_W + BW];
         item_bucket_ff <= q_data[HASH_W +: BW];
         item_fp_ff <= q_data[HASH_W-1:0];
      end
      if (state_ff == BK_READ) begin
         hit_found_ff <= hit_found_in;
         hit_empty_ff <= hit_empty_in;
         hit_idx_ff <= hit_idx_in;
         qm_found_ff <= qm_found_in;
         qm_idx_ff <= qm_idx_in;
         min_idx_ff <= min_idx_in;
      end
      if (state_ff == BK_EVAL) begin
         wr_slot_ff <= wr_slot_in;
         wr_idx_ff <= wr_idx_in;
         wr_val_ff <= wr_val_in;
         vote_mid_ff <= vote_mid_in;
         vote_step_ff <= vote_step_in;
         cnt_out_ff <= cnt_out_in;
      end
      if (rsp_load) begin
         rsp_count_ff <= cnt_out_ff;
      end
   end

   // The first slot that is empty or matches decides an insert.
   always_comb begin
      hit_found_in = 1'b0;
      hit_idx_in = '0;
      qm_found_in = 1'b0;
      qm_idx_in = '0;
      for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
         if (rd_row_ff[i].counter == '0 || rd_row_ff[i].fingerprint == item_fp_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in = IW'(i);
         end
         if (rd_row_ff[i].fingerprint == item_fp_ff) begin
            qm_found_in = 1'b1;
            qm_idx_in = IW'(i);
         end
      end
      hit_empty_in = (rd_row_ff[hit_idx_in].counter == '0);
   end

   // Ties in the minimum tree keep the left branch, so the lowest slot wins.
   always_comb begin
      node_val[0] = '0;
      node_idx[0] = '0;
      for (int k = 0; k < TREE_W; k++) begin
         if (k < SLOTS_PER_BUCKET) begin
            node_val[TREE_W + k] = {1'b0, rd_row_ff[k].counter};
         end else begin
            node_val[TREE_W + k] = 32'h80000000;
         end
         node_idx[TREE_W + k] = IW'(k);
      end
      for (int k = TREE_W - 1; k >= 1; k--) begin
         if (node_val[2*k + 1] < node_val[2*k]) begin
            node_val[k] = node_val[2*k + 1];
            node_idx[k] = node_idx[2*k + 1];
         end else begin
            node_val[k] = node_val[2*k];
            node_idx[k] = node_idx[2*k];
         end
      end
      min_idx_in = node_idx[1];
   end

   always_comb begin
      slot_type                 hs;
      slot_type                 ms;
      logic                     sign_neg;
      logic signed [VOTE_W:0]   vx;
      logic signed [VOTE_W:0]   vote_sgn;
      logic signed [VOTE_W:0]   credit;
      hs = rd_row_ff[hit_idx_ff];
      ms = rd_row_ff[min_idx_ff];
      sign_neg = item_fp_ff[0];
      vx = {rd_vote_ff[VOTE_W-1], rd_vote_ff};
      vote_sgn = sign_neg ? -vx : vx;
      credit = ms.fingerprint[0] ? -$signed({2'b00, ms.counter})
                                 : $signed({2'b00, ms.counter});
      wr_slot_in = 1'b0;
      wr_idx_in = hit_idx_ff;
      wr_val_in = hs;
      vote_mid_in = rd_vote_ff;
      vote_step_in = 1'b0;
      if (hit_found_ff) begin
         wr_slot_in = 1'b1;
         if (hit_empty_ff) begin
            wr_val_in = '{fingerprint: item_fp_ff, counter: 31'd1, is_real: 1'b1};
         end else begin
            wr_val_in.counter = cnt_inc(hs.counter);
            vote_step_in = !hs.is_real;
         end
      end else begin
         vote_step_in = 1'b1;
         if (vote_sgn >= $signed({2'b00, ms.counter})) begin
            wr_slot_in = 1'b1;
            wr_idx_in = min_idx_ff;
            wr_val_in = '{fingerprint: item_fp_ff, counter: cnt_inc(ms.counter),
                          is_real: 1'b0};
            if (ms.is_real) begin
               vote_mid_in = vote_sat_add(rd_vote_ff, credit);
            end
         end
      end
      cnt_out_in = qm_found_ff ? rd_row_ff[qm_idx_ff].counter : '0;
   end

   always_comb begin
      wr_row = rd_row_ff;
      vote_fin = vote_mid_ff;
      if (state_ff == BK_CLEAR) begin
         wr_row = '0;
         vote_fin = '0;
      end else begin
         if (wr_slot_ff) begin
            wr_row[wr_idx_ff] = wr_val_ff;
         end
         if (vote_step_ff) begin
            vote_fin = vote_sat_add(vote_mid_ff, item_fp_ff[0] ? -33'sd1 : 33'sd1);
         end
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.flow_count = rsp_count_ff;

endmodule

FILE: design/heavy_hitter_bucket_sketch_unit.sv
// The bucket read-modify-write sequencer takes one item at a time, through its idle,
// read, evaluate and write states; write stalls while an earlier query result waits.
// The hash front end is an 8-stage pipeline and a 2-entry queue feeds the sequencer.
// Reset is synchronous; after it the bucket memory is cleared one bucket a cycle,
// and no request beat is taken until the clearing is done.
module heavy_hitter_bucket_sketch_unit import hhbs_pkg::*; #(
   parameter int NUM_BUCKETS = 512,
   parameter int SLOTS_PER_BUCKET = 16
) (
   input  logic        clock,
   input  logic        reset,
   hhbs_req_if.sink    req_ch,
   hhbs_rsp_if.source  rsp_ch
);

   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int QW = 1 + BW + HASH_W;

   queue_status_type  q_stat;
   logic              clear_busy;
   logic              ent_push;
   logic              ent_type;
   logic [BW-1:0]     ent_bucket;
   logic [HASH_W-1:0] ent_fp;
   logic              q_pop;
   logic [QW-1:0]     q_data;

   hhbs_front #(
      .NUM_BUCKETS(NUM_BUCKETS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .hold(clear_busy),
      .q_stat(q_stat),
      .ent_push(ent_push),
      .ent_type(ent_type),
      .ent_bucket(ent_bucket),
      .ent_fp(ent_fp)
   );

   hhbs_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(ent_push),
      .push_data({ent_type, ent_bucket, ent_fp}),
      .pop(q_pop),
      .pop_data(q_data),
      .stat(q_stat)
   );

   hhbs_back #(
      .NUM_BUCKETS(NUM_BUCKETS),
      .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_stat(q_stat),
      .q_data(q_data),
      .q_pop(q_pop),
      .clear_busy(clear_busy),
      .rsp(rsp_ch)
   );

endmodule

FILE: tb/tb_heavy_hitter_bucket_sketch_unit.sv
`timescale 1ns / 100ps

module tb_heavy_hitter_bucket_sketch_unit import hhbs_pkg::*; ();

   localparam int BUCKETS = 512;
   localparam int SLOTS = 16;
   localparam int RANDOM_BEATS = 1000;
   localparam int HOT_SETS = 4;
   localparam int FLOWS_PER_SET = 40;

   typedef struct {
      logic              kind;
      logic [HASH_W-1:0] hash;
      bit                known;
      logic [CNT_W-1:0]  count;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hhbs_req_if req_ch ();
   hhbs_rsp_if rsp_ch ();

   heavy_hitter_bucket_sketch_unit #(
      .NUM_BUCKETS(BUCKETS),
      .SLOTS_PER_BUCKET(SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #2 clock = ~clock;

   logic [HASH_W-1:0]        slot_fp [BUCKETS*SLOTS];
   logic [CNT_W-1:0]         slot_tally [BUCKETS*SLOTS];
   bit                       slot_real [BUCKETS*SLOTS];
   logic signed [VOTE_W-1:0] bucket_bias [BUCKETS];

   logic [CNT_W-1:0] expected_counts [$];
   int               fault_count = 0;
   bit               steady_run = 1'b0;

   probe_row_type opening_rows [16] = '{
      '{REQ_QUERY,  31'h00000000, 1'b1, 31'd0},
      '{REQ_QUERY,  31'h7FFFFFFF, 1'b1, 31'd0},
      '{REQ_QUERY,  31'h2AAAAAAA, 1'b1, 31'd0},
      '{REQ_INSERT, 31'h00000000, 1'b0, 31'd0},
      '{REQ_QUERY,  31'h00000000, 1'b1, 31'd1},
      '{REQ_INSERT, 31'h00000000, 1'b0, 31'd0},
      '{REQ_QUERY,  31'h00000000, 1'b1, 31'd2},
      '{REQ_INSERT, 31'h7FFFFFFF, 1'b0, 31'd0},
      '{REQ_INSERT, 31'h55555555, 1'b0, 31'd0},
      '{REQ_QUERY,  31'h7FFFFFFF, 1'b1, 31'd1},
      '{REQ_QUERY,  31'h55555555, 1'b0, 31'd0},
      '{REQ_INSERT, 31'h00000200, 1'b0, 31'd0},
      '{REQ_QUERY,  31'h00000200, 1'b0, 31'd0},
      '{REQ_QUERY,  31'h00000400, 1'b0, 31'd0},
      '{REQ_INSERT, 31'h2AAAAAAA, 1'b0, 31'd0},
      '{REQ_QUERY,  31'h2AAAAAAA, 1'b0, 31'd0}
   };

   function automatic logic [HASH_W-1:0] scramble_hash(logic [HASH_W-1:0] h);
      logic [31:0] x;
      x = {1'b0, h};
      x = x ^ (x >> 16);
      x = x * FP_MUL1;
      x = x ^ (x >> 13);
      x = x * FP_MUL2;
      x = x ^ (x >> 16);
      return x[HASH_W-1:0];
   endfunction

   function automatic logic signed [VOTE_W-1:0] clamp_bias(logic signed [VOTE_W-1:0] v,
                                                          longint d);
      longint s;
      s = longint'(v) + d;
      if (s > 64'sd2147483647) begin
         s = 64'sd2147483647;
      end else if (s < -64'sd2147483648) begin
         s = -64'sd2147483648;
      end
      return s[VOTE_W-1:0];
   endfunction

   function automatic logic [CNT_W-1:0] bump_tally(logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
   endfunction

   function automatic void tally_insert(logic [HASH_W-1:0] h);
      int                bucket;
      int                base;
      int                s;
      int                victim;
      logic [HASH_W-1:0] fp;
      logic [CNT_W-1:0]  low_tally;
      longint            step;
      longint            evicted;
      bucket = int'(h % BUCKETS);
      base = bucket * SLOTS;
      fp = scramble_hash(h);
      step = fp[0] ? -64'sd1 : 64'sd1;
      low_tally = '0;
      victim = base;
      for (int i = 0; i < SLOTS; i++) begin
         s = base + i;
         if (slot_tally[s] == '0) begin
            slot_fp[s] = fp;
            slot_tally[s] = 31'd1;
            slot_real[s] = 1'b1;
            return;
         end
         if (slot_fp[s] == fp) begin
            slot_tally[s] = bump_tally(slot_tally[s]);
            if (!slot_real[s]) begin
               bucket_bias[bucket] = clamp_bias(bucket_bias[bucket], step);
            end
            return;
         end
         if (i == 0 || slot_tally[s] < low_tally) begin
            low_tally = slot_tally[s];
            victim = s;
         end
      end
      if (longint'(bucket_bias[bucket]) * step >= longint'(low_tally)) begin
         if (slot_real[victim]) begin
            evicted = (slot_fp[victim][0] ? -64'sd1 : 64'sd1) * longint'(slot_tally[victim]);
            bucket_bias[bucket] = clamp_bias(bucket_bias[bucket], evicted);
         end
         slot_fp[victim] = fp;
         slot_tally[victim] = bump_tally(slot_tally[victim]);
         slot_real[victim] = 1'b0;
      end
      bucket_bias[bucket] = clamp_bias(bucket_bias[bucket], step);
   endfunction

   function automatic logic [CNT_W-1:0] tally_lookup(logic [HASH_W-1:0] h);
      int                base;
      logic [HASH_W-1:0] fp;
      base = int'(h % BUCKETS) * SLOTS;
      fp = scramble_hash(h);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_fp[base + i] == fp) begin
            return slot_tally[base + i];
         end
      end
      return '0;
   endfunction

   function automatic void note_fault(string what, logic [CNT_W-1:0] want,
                                      logic [CNT_W-1:0] got);
      if (fault_count < 10) begin
         $display("%0t: %s: expected flow_count %0d, got %0d", $realtime, what, want, got);
      end
      fault_count++;
   endfunction

   task automatic send_beat(logic kind, logic [HASH_W-1:0] hash, bit known,
                            logic [CNT_W-1:0] count);
      while (!steady_run && $urandom_range(99) < 22) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.flow_hash <= hash;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      if (kind == REQ_INSERT) begin
         tally_insert(hash);
      end else begin
         expected_counts = {expected_counts, known ? count : tally_lookup(hash)};
      end
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= steady_run || ($urandom_range(99) >= 22);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_counts.size() == 0) begin
            note_fault("result beat with nothing pending", '0, rsp_ch.flow_count);
         end else if (rsp_ch.flow_count !== expected_counts[0]) begin
            note_fault("flow_count mismatch", expected_counts[0], rsp_ch.flow_count);
            void'(expected_counts.pop_front());
         end else begin
            void'(expected_counts.pop_front());
         end
      end
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      logic [8:0]        hot_bucket [HOT_SETS];
      logic [HASH_W-1:0] flow_pool [HOT_SETS][FLOWS_PER_SET];
      logic [HASH_W-1:0] hash;
      logic              kind;
      int                pick;
      int                roll;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_INSERT;
      req_ch.flow_hash = '0;
      for (int i = 0; i < BUCKETS * SLOTS; i++) begin
         slot_fp[i] = '0;
         slot_tally[i] = '0;
         slot_real[i] = 1'b0;
      end
      for (int b = 0; b < BUCKETS; b++) begin
         bucket_bias[b] = '0;
      end
      for (int g = 0; g < HOT_SETS; g++) begin
         hot_bucket[g] = 9'($urandom_range(BUCKETS - 1));
         for (int k = 0; k < FLOWS_PER_SET; k++) begin
            flow_pool[g][k] = {22'($urandom), hot_bucket[g]};
         end
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_rows[r]) begin
         send_beat(opening_rows[r].kind, opening_rows[r].hash, opening_rows[r].known,
                   opening_rows[r].count);
      end
      drain_results();

      // Most beats land on a few crowded buckets so that slots fill up and get replaced.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         steady_run = (n >= 400 && n < 600);
         if (n == 700) begin
            drain_results();
         end
         roll = $urandom_range(99);
         pick = ($urandom_range(1) == 0) ? $urandom_range(7) : $urandom_range(FLOWS_PER_SET - 1);
         if (roll < 70) begin
            hash = flow_pool[$urandom_range(HOT_SETS - 1)][pick];
            kind = ($urandom_range(99) < 35) ? REQ_QUERY : REQ_INSERT;
         end else if (roll < 90) begin
            hash = 31'($urandom);
            kind = ($urandom_range(1) == 0) ? REQ_QUERY : REQ_INSERT;
         end else begin
            hash = {22'($urandom), hot_bucket[$urandom_range(HOT_SETS - 1)]};
            kind = REQ_QUERY;
         end
         send_beat(kind, hash, 1'b0, '0);
      end
      steady_run = 1'b0;

      drain_results();
      repeat (30) @(posedge clock);
      if (fault_count == 0 && expected_counts.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: files.f
design/hhbs_pkg.sv
design/hhbs_if.sv
design/hhbs_front.sv
design/hhbs_queue.sv
design/hhbs_back.sv
design/heavy_hitter_bucket_sketch_unit.sv
tb/tb_heavy_hitter_bucket_sketch_unit.sv
